### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is held. Expects clk and rst_n in scope.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");

// Clocked check that also holds while reset is held.
`define ASSERT_CLK_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("%m: check failed");

`endif

### hdl/mpr_pkg.sv
`timescale 1ns / 1ps

package mpr_pkg;

  // Field and register widths
  localparam int PIX_W     = 8;
  localparam int CFG_DIM_W = 13;
  localparam int CFG_SLC_W = 9;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = CFG_DIM_W + CFG_SLC_W;

  localparam logic [PIX_W-1:0] PIX_BIAS = 8'h80;

  // Parameter defaults
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int MAX_SLICES_DEF = 256;

  // Reset values of the registers
  localparam logic [CFG_DIM_W-1:0] RST_FRAME_WIDTH  = 13'd1920;
  localparam logic [CFG_DIM_W-1:0] RST_FRAME_HEIGHT = 13'd1080;
  localparam logic [CFG_SLC_W-1:0] RST_SLICE_COUNT  = 9'd1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EVEN_ROW_ALIGN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTERLACE_MODE = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic accept;       // latch residual, wrap counters if out of range
    logic slice_reset;  // first slice of the frame
    logic slice_step;   // move on to the next slice
    logic mul_load;     // register (slice_index + 1) * height
    logic div_start;    // divide product by slice count
    logic ram_rd;       // read the pixel above
    logic calc;         // reconstruct, write back, advance, load output
  } mpr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic col_zero;
    logic row_zero;
    logic scan_more;
    logic div_busy;
    logic div_done;
    logic out_free;
  } mpr_stat_t;

endpackage

### hdl/mpr_ram.sv
`timescale 1ns / 1ps

module mpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/mpr_div.sv
`timescale 1ns / 1ps

module mpr_div #(
  parameter int NW = 22,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = (NW > 1) ? $clog2(NW) : 1;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;

  // One quotient bit per cycle, restoring
  assign shifted = {rem_r, quo_r[NW-1]};
  assign ge      = shifted >= {1'b0, divisor};
  assign diff    = shifted - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : shifted[DW-1:0];
      quo_nxt = {quo_r[NW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### hdl/mpr_dp.sv
`timescale 1ns / 1ps

module mpr_dp #(
  parameter int MAX_WIDTH  = mpr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mpr_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_SLICES = mpr_pkg::MAX_SLICES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mpr_pkg::mpr_cmd_t              cmd,
  output mpr_pkg::mpr_stat_t             stat,
  input  logic [mpr_pkg::PIX_W-1:0]      in_residual,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mpr_pkg::PIX_W-1:0]      out_pixel,
  output logic                           out_frame_end,
  input  logic                           cfg_valid,
  input  logic [mpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mpr_pkg::CFG_DIM_W-1:0]  cfg_data
);

  import mpr_pkg::*;

  localparam int DEPTH = 2 * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  // Configuration
  logic [CFG_DIM_W-1:0] width_r, height_r;
  logic [CFG_SLC_W-1:0] slices_r;
  logic                 align_r, ilace_r;
  logic                 cfg_hit;

  logic [CFG_DIM_W-1:0] w_eff, h_eff;
  logic [CFG_SLC_W-1:0] s_eff;

  // Position and prediction state
  logic [CFG_DIM_W-1:0] col_r, row_r, first_r, next_r;
  logic [CFG_SLC_W-1:0] idx_r;
  logic [PIX_W-1:0]     left_r, corner_r, res_r;
  logic [PROD_W-1:0]    prod_r;
  logic [CFG_SLC_W-1:0] mul_k;

  logic                 out_valid_r;
  logic [PIX_W-1:0]     out_pixel_r;
  logic                 out_frame_end_r;

  logic                 div_busy, div_done;
  logic [PROD_W-1:0]    div_quo;
  logic [CFG_DIM_W-1:0] bound_mask;

  logic [AW-1:0]        rd_addr, wr_addr;
  logic [PIX_W-1:0]     top;

  logic                 wrap;
  logic                 col_last, row_last;
  logic                 in_slice;
  logic [CFG_DIM_W-1:0] rel;
  logic                 line_first, line_second;
  logic [PIX_W-1:0]     grad, lo, hi, med, pred, pix;

  assign w_eff = (width_r == '0) ? CFG_DIM_W'(1) :
                 (32'(width_r) > MAX_WIDTH) ? CFG_DIM_W'(MAX_WIDTH) : width_r;
  assign h_eff = (height_r == '0) ? CFG_DIM_W'(1) :
                 (32'(height_r) > MAX_HEIGHT) ? CFG_DIM_W'(MAX_HEIGHT) : height_r;
  assign s_eff = (slices_r == '0) ? CFG_SLC_W'(1) :
                 (32'(slices_r) > MAX_SLICES) ? CFG_SLC_W'(MAX_SLICES) : slices_r;

  assign cfg_hit = cfg_valid && (cfg_index == REG_FRAME_WIDTH ||
                                 cfg_index == REG_FRAME_HEIGHT ||
                                 cfg_index == REG_SLICE_COUNT ||
                                 cfg_index == REG_EVEN_ROW_ALIGN ||
                                 cfg_index == REG_INTERLACE_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_FRAME_WIDTH;
      height_r <= RST_FRAME_HEIGHT;
      slices_r <= RST_SLICE_COUNT;
      align_r  <= 1'b0;
      ilace_r  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:    width_r  <= cfg_data;
        REG_FRAME_HEIGHT:   height_r <= cfg_data;
        REG_SLICE_COUNT:    slices_r <= cfg_data[CFG_SLC_W-1:0];
        REG_EVEN_ROW_ALIGN: align_r  <= cfg_data[0];
        REG_INTERLACE_MODE: ilace_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Slice bound: (k * height) / slices, rounded down
  assign mul_k = idx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod_r <= PROD_W'(mul_k) * PROD_W'(h_eff);
    end
  end

  mpr_div #(
    .NW (PROD_W),
    .DW (CFG_SLC_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (s_eff),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign bound_mask = {{(CFG_DIM_W-2){1'b1}}, !(ilace_r && align_r), !(ilace_r || align_r)};

  // Line store: two rows, bank chosen by row parity
  assign rd_addr = (row_r[0] ^ !ilace_r) ? AW'(MAX_WIDTH) + AW'(col_r) : AW'(col_r);
  assign wr_addr = row_r[0] ? AW'(MAX_WIDTH) + AW'(col_r) : AW'(col_r);

  mpr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (cmd.calc),
    .waddr (wr_addr),
    .wdata (pix),
    .re    (cmd.ram_rd),
    .raddr (rd_addr),
    .rdata (top)
  );

  // Prediction
  assign wrap      = (col_r >= w_eff) || (row_r >= h_eff);
  assign col_last  = col_r == w_eff - 1'b1;
  assign row_last  = row_r == h_eff - 1'b1;
  assign in_slice  = (row_r >= first_r) && (row_r < next_r);
  assign rel       = row_r - first_r;
  assign line_first  = ilace_r ? (rel[CFG_DIM_W-1:1] == '0) : (rel == '0);
  assign line_second = ilace_r ? (rel == CFG_DIM_W'(2)) : (rel == CFG_DIM_W'(1));

  assign grad = left_r + top - corner_r;
  assign lo   = (left_r < top) ? left_r : top;
  assign hi   = (left_r < top) ? top : left_r;
  assign med  = (grad < lo) ? lo : (grad > hi) ? hi : grad;

  always_comb begin
    if (line_first) begin
      pred = (rel == '0 && col_r == '0) ? PIX_BIAS : left_r;
    end else if (line_second && col_r == '0) begin
      pred = top;
    end else begin
      pred = med;
    end
  end

  assign pix = in_slice ? (res_r + pred) : res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      idx_r    <= '0;
      first_r  <= '0;
      next_r   <= '0;
      left_r   <= '0;
      corner_r <= '0;
    end else if (cfg_hit || (cmd.accept && wrap)) begin
      // restart the frame
      col_r    <= '0;
      row_r    <= '0;
      idx_r    <= '0;
      first_r  <= '0;
      next_r   <= '0;
      left_r   <= '0;
      corner_r <= '0;
    end else begin
      if (cmd.slice_reset) begin
        idx_r   <= '0;
        first_r <= '0;
      end
      if (cmd.slice_step) begin
        idx_r   <= idx_r + 1'b1;
        first_r <= next_r;
      end
      if (div_done) begin
        next_r <= div_quo[CFG_DIM_W-1:0] & bound_mask;
      end
      if (cmd.calc) begin
        if (in_slice) begin
          left_r <= pix;
          if (!line_first) begin
            corner_r <= top;
          end
        end
        if (col_last) begin
          col_r <= '0;
          row_r <= row_last ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_r <= in_residual;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.calc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.calc) begin
      out_pixel_r     <= pix;
      out_frame_end_r <= col_last && row_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel     = out_pixel_r;
  assign out_frame_end = out_frame_end_r;

  assign stat.col_zero  = col_r == '0;
  assign stat.row_zero  = row_r == '0;
  assign stat.scan_more = (row_r >= next_r) &&
                          ({1'b0, idx_r} + 1'b1 < {1'b0, s_eff});
  assign stat.div_busy  = div_busy;
  assign stat.div_done  = div_done;
  assign stat.out_free  = !out_valid_r || !out_stall;

endmodule

### hdl/mpr_ctrl.sv
`timescale 1ns / 1ps

module mpr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mpr_pkg::mpr_stat_t stat,
  output mpr_pkg::mpr_cmd_t  cmd
);

  import mpr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POS,
    S_SCAN,
    S_MUL,
    S_DSTART,
    S_DWAIT,
    S_CALC
  } state_t;

  state_t state_r, state_nxt;
  logic   stall_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !stall_r) begin
          cmd.accept = 1'b1;
          state_nxt  = S_POS;
        end
      end
      S_POS: begin
        if (stat.col_zero && stat.row_zero) begin
          cmd.slice_reset = 1'b1;
          state_nxt       = S_MUL;
        end else if (stat.col_zero) begin
          state_nxt = S_SCAN;
        end else begin
          cmd.ram_rd = 1'b1;
          state_nxt  = S_CALC;
        end
      end
      S_SCAN: begin
        // skip past slices that already ended, empty ones included
        if (stat.scan_more) begin
          cmd.slice_step = 1'b1;
          state_nxt      = S_MUL;
        end else begin
          cmd.ram_rd = 1'b1;
          state_nxt  = S_CALC;
        end
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (stat.div_done) begin
          state_nxt = S_SCAN;
        end
      end
      S_CALC: begin
        // hold until the output register can take the item
        if (stat.out_free) begin
          cmd.calc  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stall_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      stall_r <= state_nxt != S_IDLE;
    end
  end

  assign in_stall = stall_r;

endmodule

### hdl/median_prediction_restore.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Median prediction restore for one 8-bit plane. Residuals enter in raster
// order, one reconstructed pixel leaves per residual. One item at a time is
// in work: a pixel inside a row goes through accept, line store read and
// reconstruct, and the first pixel of a row also passes a slice scan. At the
// first pixel of a frame, and each time a row start crosses into a new
// slice, the next slice bound is computed by a serial divider:
// (slice_index + 1) * height / slice_count, one quotient bit per cycle. A
// further bound is computed for each slice stepped past at a row start. A
// finished pixel waits in the output register while the next residual is
// taken. Configuration writes are taken at any time but are meant for idle
// periods; any write to a known register restarts the frame.
module median_prediction_restore #(
  parameter int MAX_WIDTH  = mpr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mpr_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_SLICES = mpr_pkg::MAX_SLICES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mpr_pkg::PIX_W-1:0]     in_residual,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mpr_pkg::PIX_W-1:0]     out_pixel,
  output logic                          out_frame_end,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpr_pkg::CFG_DIM_W-1:0] cfg_data
);

  import mpr_pkg::*;

  mpr_cmd_t  cmd;
  mpr_stat_t stat;

  assign cfg_ready = 1'b1;

  mpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mpr_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_SLICES (MAX_SLICES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_residual   (in_residual),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel     (out_pixel),
    .out_frame_end (out_frame_end),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  `ASSERT_CLK(a_one_in_flight, (in_valid && !in_stall) |=> in_stall)
  `ASSERT_CLK(a_calc_needs_room, cmd.calc |-> stat.out_free)
  `ASSERT_CLK(a_div_start_idle, cmd.div_start |-> !stat.div_busy)
  `ASSERT_CLK_ALWAYS(a_stall_in_reset, !rst_n |=> in_stall)

endmodule
